### src/ilist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list package
// Shared types and codes for the indexed list insert/delete block.
// ----------------------------------------------------------------------------
package ilist_pkg;

	// Operation codes carried in the func field.
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;

	// One request item.
	typedef struct packed {
		logic [1:0]  func;
		logic [5:0]  position;
		logic [31:0] entry_data;
	} req_t;

	// One result item.
	typedef struct packed {
		logic        ok;
		logic [5:0]  list_length;
		logic [31:0] read_data;
	} res_t;

	// Command from the controller to the datapath for the item in execution.
	typedef struct packed {
		logic strobe;
		logic ok;
		logic ins;
		logic del;
		logic rd;
	} cmd_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

endpackage

### src/ilist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list controller
// Captures a request, checks its position against the length and issues
// the insert, delete or read command to the datapath.
// ----------------------------------------------------------------------------
module ilist_ctrl #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  ilist_pkg::req_t              request,
	input  logic [$clog2(CAPACITY+1)-1:0] count,
	output ilist_pkg::cmd_t              cmd,
	output logic [$clog2(CAPACITY)-1:0]  idx,
	output logic [DATA_WIDTH-1:0]        wdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int VW = (CW > 6) ? CW : 6;

	ilist_pkg::ctrl_state_t state_q, state_d;

	logic [1:0]            func_s1;
	logic [5:0]            pos_s1;
	logic [DATA_WIDTH-1:0] data_s1;

	logic [VW-1:0] pos_v;
	logic [VW-1:0] cnt_v;
	logic          pos_nz;
	logic          ins_ok;
	logic          in_range;

	// Execution never stalls, so a new request is always taken.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilist_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			func_s1 <= request.func;
			pos_s1  <= request.position;
			data_s1 <= DATA_WIDTH'(request.entry_data);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ilist_pkg::ST_IDLE: state_d = start ? ilist_pkg::ST_EXEC : ilist_pkg::ST_IDLE;
			ilist_pkg::ST_EXEC: state_d = start ? ilist_pkg::ST_EXEC : ilist_pkg::ST_IDLE;
			default:            state_d = ilist_pkg::ST_IDLE;
		endcase
	end

	// Range checks are done at a width that holds both the position field and
	// the length, so a large position is never folded into range.
	assign pos_v    = VW'(pos_s1);
	assign cnt_v    = VW'(count);
	assign pos_nz   = (pos_s1 != 6'd0);
	assign ins_ok   = pos_nz && ((pos_v - VW'(1)) <= cnt_v) && (count < CW'(CAPACITY));
	assign in_range = pos_nz && (pos_v <= cnt_v);

	always_comb begin
		cmd = '0;
		if (state_q == ilist_pkg::ST_EXEC) begin
			cmd.strobe = 1'b1;
			unique case (func_s1)
				ilist_pkg::FUNC_INSERT: begin
					cmd.ins = ins_ok;
					cmd.ok  = ins_ok;
				end
				ilist_pkg::FUNC_DELETE: begin
					cmd.del = in_range;
					cmd.ok  = in_range;
				end
				ilist_pkg::FUNC_READ: begin
					cmd.rd = in_range;
					cmd.ok = in_range;
				end
				default: begin
					cmd.ok = 1'b0;
				end
			endcase
		end
	end

	assign idx   = IW'(pos_v - VW'(1));
	assign wdata = data_s1;

	// A command names at most one operation.
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ins, cmd.del, cmd.rd}))
		else $error("more than one list operation at once");

	// An operation is only issued for an accepted item in execution.
	a_op_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins || cmd.del || cmd.rd) |-> (cmd.ok && cmd.strobe))
		else $error("operation issued without an accepted item");

	// An accepted item is always in execution in the cycle after it is taken.
	a_exec_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ilist_pkg::ST_EXEC))
		else $error("accepted item did not reach execution");

endmodule

### src/ilist_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list datapath
// Row of entry cells that shift up or down all at once, the length count
// and the result register.
// ----------------------------------------------------------------------------
module ilist_dp #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ilist_pkg::cmd_t               cmd,
	input  logic [$clog2(CAPACITY)-1:0]   idx,
	input  logic [DATA_WIDTH-1:0]         wdata,
	output logic [$clog2(CAPACITY+1)-1:0] count,
	output logic                          done,
	output ilist_pkg::res_t               result
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [DATA_WIDTH-1:0] cells_q [CAPACITY];
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [CW-1:0]         idx_c;

	logic        done_q;
	logic        ok_q;
	logic [5:0]  len_q;
	logic [31:0] rd_q;

	assign idx_c = CW'(idx);

	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + CW'(1);
		end else if (cmd.del) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= cmd.strobe;
		end
	end

	// Each cell compares its own index with the position and the length and
	// either holds, takes its lower neighbor (insert) or its upper neighbor
	// (delete). The cell at the position takes the new word on insert.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam logic [CW-1:0] CELL_IDX  = CW'(g);
		localparam logic [CW-1:0] CELL_NEXT = CW'(g + 1);

		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				if (CELL_IDX == idx_c) begin
					cells_q[g] <= wdata;
				end else if ((g > 0) && (CELL_IDX > idx_c) && (CELL_IDX <= count_q)) begin
					cells_q[g] <= cells_q[(g > 0) ? g - 1 : 0];
				end
			end else if (cmd.del) begin
				if ((g < CAPACITY - 1) && (CELL_IDX >= idx_c) && (CELL_NEXT < count_q)) begin
					cells_q[g] <= cells_q[(g < CAPACITY - 1) ? g + 1 : g];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.strobe) begin
			ok_q  <= cmd.ok;
			len_q <= 6'(count_d);
			rd_q  <= cmd.rd ? 32'(cells_q[idx]) : 32'd0;
		end
	end

	assign count              = count_q;
	assign done               = done_q;
	assign result.ok          = ok_q;
	assign result.list_length = len_q;
	assign result.read_data   = rd_q;

	// The length never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length above capacity");

	// An insert grows the list by exactly one entry.
	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list by one");

	// A delete shrinks the list by exactly one entry.
	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del |=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete did not shrink the list by one");

	// Reads and rejected items leave the length alone.
	a_len_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins || cmd.del) |=> $stable(count_q))
		else $error("list length changed without insert or delete");

endmodule

### src/indexed_list_insert_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list insert/delete
// Ordered list of data words with insert, delete and read at a 1-based
// position, plus a length count.
// ----------------------------------------------------------------------------
// Usage:
// A request item is taken at a rising edge where start is high and busy is
// low. It carries func (insert, delete or read), a 1-based position and a
// data word used by insert only. busy is always low: the block takes an item
// in every cycle.
// Each item yields one result item. It is shown on result for exactly one
// cycle with done high, once the request has been registered in the
// controller and the result has been registered in the datapath.
// Throughput is one item per cycle. The entries form a row of registers in
// which every cell decides to hold or shift from a compare against the
// position and the length, so a whole insert or delete completes in the
// execution state and the next item sees the updated list.
// A request out of range, an insert into a full list or an unused func code
// gives ok low, the length unchanged and read_data zero.
// Reset clears the length to zero and drops any item in flight; the entry
// words are not cleared, as only entries below the length are ever read.
// The receiver has no way to stall results and must take each one as shown.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_top #(
	parameter int CAPACITY   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ilist_pkg::req_t request,
	output logic            done,
	output ilist_pkg::res_t result
);

	// Command and status between controller and datapath.
	ilist_pkg::cmd_t               cmd;
	logic [$clog2(CAPACITY)-1:0]   idx;
	logic [DATA_WIDTH-1:0]         wdata;
	logic [$clog2(CAPACITY+1)-1:0] count;

	// The controller registers the request and validates it against the
	// current length during the execution cycle.
	ilist_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.count   (count),
		.cmd     (cmd),
		.idx     (idx),
		.wdata   (wdata)
	);

	// The datapath shifts the cells, updates the length and registers the
	// result at the end of the execution cycle.
	ilist_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.idx    (idx),
		.wdata  (wdata),
		.count  (count),
		.done   (done),
		.result (result)
	);

endmodule

### bench/tb_indexed_list_insert_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list insert/delete testbench
// Drives insert, delete and read items at 1-based positions into the list
// block. A shadow copy of the list predicts every result item, and each
// strobed result is checked against the oldest prediction. A short
// directed sequence comes first. A fill to capacity follows, and then
// randomized grow, shrink and churn episodes with noise items mixed in.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_delete_top;

	localparam int CAPACITY    = 32;
	localparam int DATA_WIDTH  = 32;
	localparam int ITEM_TARGET = 1550;
	// This bound on the run time is far beyond what a correct run needs.
	localparam int RUN_LIMIT_NS = 2_000_000;

	// The one func code that names no operation.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// Mixes of operations that steer the list length up, down or keep it level.
	typedef enum int {
		MIX_GROW,
		MIX_SHRINK,
		MIX_CHURN
	} op_mix_t;

	// ------------------------------------------------------------------------
	// Shadow list: it holds its own copy of the entries and the length. It
	// turns each accepted item into the result item that the block must give.
	// ------------------------------------------------------------------------
	class list_mirror;
		logic [DATA_WIDTH-1:0] slots[CAPACITY];
		int                    fill;
		ilist_pkg::res_t       awaited_results[$];
		int                    errors;
		int                    checked;
		int                    inserts_done;
		int                    deletes_done;
		int                    reads_done;
		int                    rejected;
		int                    longest;

		function new();
			fill    = 0;
			errors  = 0;
			checked = 0;
			longest = 0;
		endfunction

		// Apply one accepted item to the shadow list and queue its result.
		function void note_request(ilist_pkg::req_t item);
			ilist_pkg::res_t outcome;
			int              pos;
			int              j;
			pos = item.position;
			outcome = '0;
			case (item.func)
				ilist_pkg::FUNC_INSERT: begin
					if (pos >= 1 && pos <= fill + 1 && fill < CAPACITY) begin
						for (j = fill; j >= pos; j--)
							slots[j] = slots[j-1];
						slots[pos-1] = item.entry_data[DATA_WIDTH-1:0];
						fill++;
						outcome.ok = 1'b1;
						inserts_done++;
					end
				end
				ilist_pkg::FUNC_DELETE: begin
					if (pos >= 1 && pos <= fill) begin
						for (j = pos - 1; j + 1 < fill; j++)
							slots[j] = slots[j+1];
						fill--;
						outcome.ok = 1'b1;
						deletes_done++;
					end
				end
				ilist_pkg::FUNC_READ: begin
					if (pos >= 1 && pos <= fill) begin
						outcome.read_data = slots[pos-1];
						outcome.ok = 1'b1;
						reads_done++;
					end
				end
				default: ;
			endcase
			if (!outcome.ok)
				rejected++;
			if (fill > longest)
				longest = fill;
			outcome.list_length = fill[5:0];
			awaited_results.push_back(outcome);
		endfunction

		// Compare one strobed result with the oldest prediction.
		function void check_result(ilist_pkg::res_t got);
			ilist_pkg::res_t want;
			if (awaited_results.size() == 0) begin
				$error("result item with no prediction waiting: ok=%0b length=%0d data=%08h",
					got.ok, got.list_length, got.read_data);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			checked++;
			if (got.ok !== want.ok) begin
				$error("field ok: expected %0b, actual %0b", want.ok, got.ok);
				errors++;
			end
			if (got.list_length !== want.list_length) begin
				$error("field list_length: expected %0d, actual %0d",
					want.list_length, got.list_length);
				errors++;
			end
			if (got.read_data !== want.read_data) begin
				$error("field read_data: expected %08h, actual %08h",
					want.read_data, got.read_data);
				errors++;
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	ilist_pkg::req_t request;
	logic            done;
	ilist_pkg::res_t result;

	list_mirror mirror = new();
	bit         gaps_on;
	int         items_sent;
	int         drains;

	indexed_list_insert_delete_top #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The block gives each result for one cycle only, so every strobe is
	// checked at the edge that ends it. Predictions are queued earlier, at
	// the accepting edge, by the driver, which keeps the two processes free of races.
	always @(posedge clk) begin
		if (done === 1'b1)
			mirror.check_result(result);
	end

	// Hard stop in case the block stops answering.
	initial begin
		#(RUN_LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	// Random filler on the request bus while start is low. The block must
	// ignore it.
	function automatic ilist_pkg::req_t junk_item();
		ilist_pkg::req_t it;
		it.func       = 2'($urandom_range(0, 3));
		it.position   = 6'($urandom_range(0, 63));
		it.entry_data = $urandom;
		return it;
	endfunction

	// Offer one item and hold it until the block takes it. Random gaps come
	// before the offer. The prediction is made in this process at the
	// accepting edge, so later generation sees the updated length.
	task automatic send_item(input ilist_pkg::req_t item);
		while (gaps_on && $urandom_range(0, 99) < 33) begin
			start   <= 1'b0;
			request <= junk_item();
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		mirror.note_request(item);
		items_sent++;
	endtask

	task automatic send_op(input logic [1:0] func, input int pos, input logic [31:0] data);
		ilist_pkg::req_t it;
		it.func       = func;
		it.position   = 6'(pos);
		it.entry_data = data;
		send_item(it);
	endtask

	// Stop offering items until every predicted result has come back.
	task automatic drain_results();
		start   <= 1'b0;
		request <= junk_item();
		while (mirror.awaited_results.size() != 0)
			@(posedge clk);
		drains++;
	endtask

	// Positions lean toward the ends of the valid range, where the shift
	// logic has its boundaries.
	function automatic int pick_position(input int top);
		int roll;
		if (top < 1)
			return 1;
		roll = $urandom_range(0, 99);
		if (roll < 12)
			return 1;
		if (roll < 25)
			return top;
		return $urandom_range(1, top);
	endfunction

	// Build one random item. Most items are well-formed for the current
	// length. A small share is noise: any func code, including the unused
	// one, and any position up to the 6-bit maximum.
	function automatic ilist_pkg::req_t make_item(input op_mix_t mix);
		ilist_pkg::req_t it;
		int              len;
		int              roll;
		int              ins_pct;
		int              del_pct;
		len = mirror.fill;
		it.entry_data = $urandom;
		if ($urandom_range(0, 99) < 8) begin
			it.func     = 2'($urandom_range(0, 3));
			it.position = 6'($urandom_range(0, 63));
			return it;
		end
		case (mix)
			MIX_GROW: begin
				ins_pct = 65;
				del_pct = 15;
			end
			MIX_SHRINK: begin
				ins_pct = 15;
				del_pct = 65;
			end
			default: begin
				ins_pct = 35;
				del_pct = 33;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < ins_pct) begin
			it.func     = ilist_pkg::FUNC_INSERT;
			it.position = 6'(pick_position(len + 1));
		end else if (roll < ins_pct + del_pct) begin
			it.func     = ilist_pkg::FUNC_DELETE;
			it.position = 6'(pick_position(len));
		end else begin
			it.func     = ilist_pkg::FUNC_READ;
			it.position = 6'(pick_position(len));
		end
		return it;
	endfunction

	initial begin
		op_mix_t mix;
		int      episode_len;
		int      k;

		// All inputs are known from time zero. Reset is held low before the run.
		arst_n     = 1'b0;
		start      = 1'b0;
		request    = '0;
		gaps_on    = 1'b1;
		items_sent = 0;
		drains     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: first requests on an empty list, then inserts at the
		// front, the back and the middle. Reads then cover every slot. Deletes
		// at the middle, the end and the front follow. Out-of-range positions,
		// position zero, the top position value and the unused func code are
		// all rejected.
		send_op(ilist_pkg::FUNC_READ,   1,  32'h0);
		send_op(ilist_pkg::FUNC_DELETE, 1,  32'h0);
		send_op(ilist_pkg::FUNC_INSERT, 0,  32'h1234_5678);
		send_op(ilist_pkg::FUNC_INSERT, 2,  32'h1234_5678);
		send_op(FUNC_UNUSED,            1,  32'hFFFF_FFFF);
		send_op(ilist_pkg::FUNC_INSERT, 1,  32'h0000_0000);
		send_op(ilist_pkg::FUNC_INSERT, 1,  32'hFFFF_FFFF);
		send_op(ilist_pkg::FUNC_INSERT, 3,  32'hA5A5_A5A5);
		send_op(ilist_pkg::FUNC_INSERT, 2,  32'h5A5A_5A5A);
		send_op(ilist_pkg::FUNC_INSERT, 63, 32'hDEAD_BEEF);
		for (k = 1; k <= 4; k++)
			send_op(ilist_pkg::FUNC_READ, k, 32'hFFFF_FFFF);
		send_op(ilist_pkg::FUNC_READ,   5,  32'h0);
		send_op(ilist_pkg::FUNC_READ,   0,  32'h0);
		send_op(ilist_pkg::FUNC_DELETE, 63, 32'h0);
		send_op(ilist_pkg::FUNC_DELETE, 2,  32'h0);
		send_op(ilist_pkg::FUNC_DELETE, 3,  32'h0);
		send_op(ilist_pkg::FUNC_DELETE, 1,  32'h0);
		send_op(ilist_pkg::FUNC_READ,   1,  32'h0);
		send_op(ilist_pkg::FUNC_DELETE, 1,  32'h0);
		send_op(ilist_pkg::FUNC_READ,   1,  32'h0);
		drain_results();

		// Fill the list to capacity at random positions. Inserts into the
		// full list must be rejected at the end position, at the front and
		// at the top position value. Then the last slot is exercised.
		while (mirror.fill < CAPACITY)
			send_op(ilist_pkg::FUNC_INSERT, $urandom_range(1, mirror.fill + 1), $urandom);
		send_op(ilist_pkg::FUNC_INSERT, CAPACITY + 1, $urandom);
		send_op(ilist_pkg::FUNC_INSERT, 1,            $urandom);
		send_op(ilist_pkg::FUNC_INSERT, 63,           $urandom);
		send_op(ilist_pkg::FUNC_READ,   CAPACITY,     $urandom);
		send_op(ilist_pkg::FUNC_READ,   CAPACITY + 1, $urandom);
		send_op(ilist_pkg::FUNC_DELETE, CAPACITY,     $urandom);
		send_op(ilist_pkg::FUNC_INSERT, CAPACITY,     $urandom);
		send_op(ilist_pkg::FUNC_DELETE, 1,            $urandom);

		// Random episodes. The mix of operations walks the length across its
		// whole range, so the full and empty limits recur. A stretch of items
		// is sent with no gaps at all, and the sender sometimes waits for
		// every outstanding result before it goes on.
		while (items_sent < ITEM_TARGET) begin
			k = $urandom_range(0, 2);
			mix = (k == 0) ? MIX_GROW : (k == 1) ? MIX_SHRINK : MIX_CHURN;
			episode_len = $urandom_range(20, 120);
			repeat (episode_len) begin
				gaps_on = !(items_sent >= 700 && items_sent < 1000);
				send_item(make_item(mix));
			end
			if ($urandom_range(0, 3) == 0)
				drain_results();
		end

		// Wait for the last results, then keep the clock running for any
		// stray strobe.
		start   <= 1'b0;
		request <= junk_item();
		while (mirror.awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d items: %0d inserts, %0d deletes, %0d reads accepted, %0d rejected.",
			items_sent, mirror.inserts_done, mirror.deletes_done, mirror.reads_done,
			mirror.rejected);
		$display("Checked %0d results; longest list %0d of %0d; %0d full drains.",
			mirror.checked, mirror.longest, CAPACITY, drains);
		if (mirror.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
